// ===== hw/rtl/ptqd_pkg.sv =====
`default_nettype none

package ptqd_pkg;

  // Sizing
  localparam int QUEUE_DEPTH = 16;
  localparam int NEST_LIMIT  = 8;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int DEP_W       = $clog2(NEST_LIMIT + 1);

  // Fixed field widths
  localparam int TAG_W   = 16;
  localparam int LVL_W   = 8;
  localparam int COUNT_W = 5;

  localparam logic [LVL_W-1:0] IDLE_LEVEL = '1;

  typedef enum logic [1:0] {
    OP_ADD      = 2'd0,
    OP_DISPATCH = 2'd1,
    OP_FINISH   = 2'd2,
    OP_NONE     = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_QUEUED     = 3'd0,
    ST_FULL       = 3'd1,
    ST_DISPATCHED = 3'd2,
    ST_NONE_ELIG  = 3'd3,
    ST_RESTORED   = 3'd4,
    ST_NOT_RUN    = 3'd5
  } status_t;

  // One queued task
  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic [LVL_W-1:0] level;
  } entry_t;

  // Broadcast to every queue cell
  typedef struct packed {
    logic   add;
    logic   pop;
    entry_t ins;
  } qctrl_t;

  // Broadcast to every stack cell
  typedef struct packed {
    logic push;
    logic pop;
  } sctrl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ptqd_if.sv =====
`default_nettype none

// Request channel
interface ptqd_in_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   op;
  logic [ptqd_pkg::TAG_W-1:0]   task_tag;
  logic [ptqd_pkg::LVL_W-1:0]   priority_req;

  modport source (output valid, op, task_tag, priority_req, input ready);
  modport sink   (input valid, op, task_tag, priority_req, output ready);
endinterface

// Result channel
interface ptqd_out_if;
  logic                         valid;
  logic                         ready;
  logic [2:0]                   status;
  logic [ptqd_pkg::TAG_W-1:0]   out_tag;
  logic [ptqd_pkg::LVL_W-1:0]   out_priority;
  logic [ptqd_pkg::LVL_W-1:0]   running_level;
  logic [ptqd_pkg::COUNT_W-1:0] queued_count;

  modport source (output valid, status, out_tag, out_priority, running_level,
                  queued_count, input ready);
  modport sink   (input valid, status, out_tag, out_priority, running_level,
                  queued_count, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/ptqd_queue_cell.sv =====
`default_nettype none

// One slot of the sorted queue. Decides locally whether to hold, take the
// new task, take the left neighbor (insert shift) or the right one (pop).
module ptqd_queue_cell (
  input  wire logic              clk,
  input  wire ptqd_pkg::qctrl_t  ctrl,
  input  wire logic              occ,
  input  wire logic              left_gt,
  input  wire ptqd_pkg::entry_t  left_data,
  input  wire ptqd_pkg::entry_t  right_data,
  output ptqd_pkg::entry_t       data,
  output logic                   gt
);

  ptqd_pkg::entry_t data_r;
  ptqd_pkg::entry_t data_nxt;

  // Slot is at or past the insert point: empty, or strictly less urgent
  assign gt = !occ || (data_r.level > ctrl.ins.level);

  always_comb begin
    data_nxt = data_r;
    if (ctrl.add && gt) begin
      data_nxt = left_gt ? left_data : ctrl.ins;
    end else if (ctrl.pop) begin
      data_nxt = right_data;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

`default_nettype wire

// ===== hw/rtl/ptqd_stack_cell.sv =====
`default_nettype none

// One slot of the saved-level stack; top of stack is slot 0.
module ptqd_stack_cell (
  input  wire logic                        clk,
  input  wire ptqd_pkg::sctrl_t            ctrl,
  input  wire logic [ptqd_pkg::LVL_W-1:0]  left_level,
  input  wire logic [ptqd_pkg::LVL_W-1:0]  right_level,
  output logic [ptqd_pkg::LVL_W-1:0]       level
);

  logic [ptqd_pkg::LVL_W-1:0] level_r;
  logic [ptqd_pkg::LVL_W-1:0] level_nxt;

  always_comb begin
    level_nxt = level_r;
    if (ctrl.push) begin
      level_nxt = left_level;
    end else if (ctrl.pop) begin
      level_nxt = right_level;
    end
  end

  always_ff @(posedge clk) begin
    level_r <= level_nxt;
  end

  assign level = level_r;

endmodule

`default_nettype wire

// ===== hw/rtl/priority_task_queue_dispatch.sv =====
`default_nettype none

// Priority task queue with dispatch and preemption level.
// in_if carries one request word (op, task_tag, priority_req); out_if returns
// one result word (status, out_tag, out_priority, running_level,
// queued_count) per request. An op of 3 is accepted and dropped silently.
// Tasks sit in a row of queue cells, sorted with head in cell 0; each cell
// compares itself to the new priority, so an add, a dispatch or a finish
// completes in the cycle the word is accepted. Saved levels live in a row
// of stack cells that shift on dispatch and finish.
// The result is valid in the cycle after acceptance. Throughput: one request
// per cycle while the receiver keeps out_if.ready high.
// The result sits in an output register; in_if.ready stays high while that
// register is empty or being drained, so a stalled receiver holds the result
// and stops further requests after one.
// Reset (rst_n low, synchronous): queue empty, no nesting, level idle (255).
module priority_task_queue_dispatch (
  input  wire logic  clk,
  input  wire logic  rst_n,
  ptqd_in_if.sink    in_if,
  ptqd_out_if.source out_if
);

  localparam int QD = ptqd_pkg::QUEUE_DEPTH;
  localparam int NL = ptqd_pkg::NEST_LIMIT;

  // Control state
  logic [ptqd_pkg::QCNT_W-1:0] fill_r, fill_nxt;
  logic [ptqd_pkg::DEP_W-1:0]  depth_r, depth_nxt;
  logic [ptqd_pkg::LVL_W-1:0]  cur_r, cur_nxt;
  logic                        out_valid_r;

  // Result register
  ptqd_pkg::status_t           res_status_r, res_status_nxt;
  ptqd_pkg::entry_t            res_entry_r, res_entry_nxt;
  logic [ptqd_pkg::LVL_W-1:0]  res_level_r;
  logic [ptqd_pkg::QCNT_W-1:0] res_fill_r;

  ptqd_pkg::qctrl_t qctrl;
  ptqd_pkg::sctrl_t sctrl;
  ptqd_pkg::entry_t q_data [QD];
  logic             q_gt   [QD];
  logic [ptqd_pkg::LVL_W-1:0] s_level [NL];

  logic accept;
  logic full, can_dispatch;
  ptqd_pkg::op_t op;

  assign in_if.ready = !out_valid_r || out_if.ready;
  assign accept      = in_if.valid && in_if.ready;
  assign op          = ptqd_pkg::op_t'(in_if.op);

  assign full         = (fill_r == ptqd_pkg::QCNT_W'(QD));
  assign can_dispatch = (fill_r != '0) && (q_data[0].level < cur_r) &&
                        (depth_r < ptqd_pkg::DEP_W'(NL));

  // Operation decode and next state
  always_comb begin
    qctrl.add       = 1'b0;
    qctrl.pop       = 1'b0;
    qctrl.ins.tag   = in_if.task_tag;
    qctrl.ins.level = in_if.priority_req;
    sctrl.push      = 1'b0;
    sctrl.pop       = 1'b0;
    fill_nxt        = fill_r;
    depth_nxt       = depth_r;
    cur_nxt         = cur_r;
    res_status_nxt  = ptqd_pkg::ST_NOT_RUN;
    res_entry_nxt   = '0;
    case (op)
      ptqd_pkg::OP_ADD: begin
        if (full) begin
          res_status_nxt = ptqd_pkg::ST_FULL;
        end else begin
          qctrl.add      = accept;
          fill_nxt       = fill_r + 1'b1;
          res_status_nxt = ptqd_pkg::ST_QUEUED;
        end
      end
      ptqd_pkg::OP_DISPATCH: begin
        if (can_dispatch) begin
          qctrl.pop      = accept;
          sctrl.push     = accept;
          fill_nxt       = fill_r - 1'b1;
          depth_nxt      = depth_r + 1'b1;
          cur_nxt        = q_data[0].level;
          res_entry_nxt  = q_data[0];
          res_status_nxt = ptqd_pkg::ST_DISPATCHED;
        end else begin
          res_status_nxt = ptqd_pkg::ST_NONE_ELIG;
        end
      end
      ptqd_pkg::OP_FINISH: begin
        if (depth_r != '0) begin
          sctrl.pop      = accept;
          depth_nxt      = depth_r - 1'b1;
          cur_nxt        = s_level[0];
          res_status_nxt = ptqd_pkg::ST_RESTORED;
        end
      end
      default: begin
      end
    endcase
  end

  // Queue cell row, head in cell 0
  for (genvar i = 0; i < QD; i++) begin : g_q
    ptqd_pkg::entry_t left_d, right_d;
    logic             left_g;
    if (i == 0) begin : g_first
      assign left_d = q_data[i];
      assign left_g = 1'b0;
    end else begin : g_mid
      assign left_d = q_data[i-1];
      assign left_g = q_gt[i-1];
    end
    if (i == QD - 1) begin : g_last
      assign right_d = q_data[i];
    end else begin : g_inner
      assign right_d = q_data[i+1];
    end
    ptqd_queue_cell u_cell (
      .clk        (clk),
      .ctrl       (qctrl),
      .occ        (ptqd_pkg::QCNT_W'(i) < fill_r),
      .left_gt    (left_g),
      .left_data  (left_d),
      .right_data (right_d),
      .data       (q_data[i]),
      .gt         (q_gt[i])
    );
  end

  // Saved-level stack row, top in cell 0
  for (genvar j = 0; j < NL; j++) begin : g_s
    logic [ptqd_pkg::LVL_W-1:0] left_l, right_l;
    if (j == 0) begin : g_first
      assign left_l = cur_r;
    end else begin : g_mid
      assign left_l = s_level[j-1];
    end
    if (j == NL - 1) begin : g_last
      assign right_l = s_level[j];
    end else begin : g_inner
      assign right_l = s_level[j+1];
    end
    ptqd_stack_cell u_cell (
      .clk         (clk),
      .ctrl        (sctrl),
      .left_level  (left_l),
      .right_level (right_l),
      .level       (s_level[j])
    );
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      depth_r     <= '0;
      cur_r       <= ptqd_pkg::IDLE_LEVEL;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        fill_r  <= fill_nxt;
        depth_r <= depth_nxt;
        cur_r   <= cur_nxt;
      end
      if (accept && (op != ptqd_pkg::OP_NONE)) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result word
  always_ff @(posedge clk) begin
    if (accept && (op != ptqd_pkg::OP_NONE)) begin
      res_status_r <= res_status_nxt;
      res_entry_r  <= res_entry_nxt;
      res_level_r  <= cur_nxt;
      res_fill_r   <= fill_nxt;
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.status        = res_status_r;
  assign out_if.out_tag       = res_entry_r.tag;
  assign out_if.out_priority  = res_entry_r.level;
  assign out_if.running_level = res_level_r;
  assign out_if.queued_count  = ptqd_pkg::COUNT_W'(res_fill_r);

endmodule

`default_nettype wire

// ===== bench/tb_priority_task_queue_dispatch.sv =====
`timescale 1ns / 1ps

module tb_priority_task_queue_dispatch;
  import ptqd_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int RANDOM_ITEMS = 750;
  // words issued in this window go out with no idling on either side
  localparam int STEADY_FROM = 300;
  localparam int STEADY_TO   = 420;

  typedef struct {
    op_t              op;
    logic [TAG_W-1:0] tag;
    logic [LVL_W-1:0] prio;
  } request_t;

  typedef struct {
    status_t            status;
    logic [TAG_W-1:0]   tag;
    logic [LVL_W-1:0]   prio;
    logic [LVL_W-1:0]   level;
    logic [COUNT_W-1:0] count;
  } outcome_t;

  logic clk;
  logic rst_n;

  ptqd_in_if  req_ch ();
  ptqd_out_if res_ch ();

  priority_task_queue_dispatch DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (req_ch),
    .out_if (res_ch)
  );

  // Stimulus and scoreboard storage
  request_t    stim_words[$];
  outcome_t    awaited_results[$];
  int unsigned items_queued;
  int unsigned words_issued;
  int unsigned results_checked;
  int unsigned mismatches;
  int unsigned quiet_cycles;
  int unsigned status_hits[6];
  int unsigned deepest_nest;
  logic        req_taken;
  logic        steady;

  // Shadow copy of the dispatcher state
  logic [TAG_W-1:0] task_tags[QUEUE_DEPTH];
  logic [LVL_W-1:0] task_levels[QUEUE_DEPTH];
  int               task_count;
  logic [LVL_W-1:0] run_level;
  logic [LVL_W-1:0] level_stack[NEST_LIMIT];
  int               nest_count;

  assign steady = (words_issued >= STEADY_FROM) && (words_issued < STEADY_TO);

  always #1 clk = ~clk;

  task automatic queue_word(input op_t op, input logic [TAG_W-1:0] tag,
                            input logic [LVL_W-1:0] prio);
    request_t w;
    w.op   = op;
    w.tag  = tag;
    w.prio = prio;
    stim_words.push_back(w);
    if (op != OP_NONE) items_queued++;
  endtask

  // Mostly mid-range levels, now and then the most urgent or the idle value
  function automatic logic [LVL_W-1:0] pick_level();
    int unsigned r;
    r = $urandom_range(255);
    if (r < 4) return '0;
    if (r == 4) return IDLE_LEVEL;
    return LVL_W'($urandom_range(1, 254));
  endfunction

  // Apply one accepted request to the shadow state and record its result
  task automatic advance_task_queue(input request_t w);
    outcome_t r;
    int       pos;
    if (w.op == OP_NONE) return;
    r.tag  = '0;
    r.prio = '0;
    case (w.op)
      OP_ADD: begin
        if (task_count >= QUEUE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          // behind every task of equal or more urgent level
          pos = 0;
          while (pos < task_count && task_levels[pos] <= w.prio) pos++;
          for (int i = task_count; i > pos; i--) begin
            task_tags[i]   = task_tags[i-1];
            task_levels[i] = task_levels[i-1];
          end
          task_tags[pos]   = w.tag;
          task_levels[pos] = w.prio;
          task_count++;
          r.status = ST_QUEUED;
        end
      end
      OP_DISPATCH: begin
        if (task_count == 0 || task_levels[0] >= run_level || nest_count >= NEST_LIMIT) begin
          r.status = ST_NONE_ELIG;
        end else begin
          r.status = ST_DISPATCHED;
          r.tag    = task_tags[0];
          r.prio   = task_levels[0];
          for (int i = 1; i < task_count; i++) begin
            task_tags[i-1]   = task_tags[i];
            task_levels[i-1] = task_levels[i];
          end
          task_count--;
          level_stack[nest_count] = run_level;
          nest_count++;
          run_level = r.prio;
          if (nest_count > deepest_nest) deepest_nest = nest_count;
        end
      end
      default: begin
        if (nest_count == 0) begin
          r.status = ST_NOT_RUN;
        end else begin
          nest_count--;
          run_level = level_stack[nest_count];
          r.status  = ST_RESTORED;
        end
      end
    endcase
    r.level = run_level;
    r.count = COUNT_W'(task_count);
    status_hits[r.status]++;
    awaited_results.push_back(r);
  endtask

  task automatic check_field(input string name, input logic [TAG_W-1:0] want,
                             input logic [TAG_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  // Driver: next word at the falling edge once the current one is taken
  always @(negedge clk) begin
    request_t w;
    if (!rst_n) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || req_taken) begin
      if (stim_words.size() != 0 && (steady || $urandom_range(99) >= 35)) begin
        w = stim_words.pop_front();
        req_ch.valid        <= 1'b1;
        req_ch.op           <= w.op;
        req_ch.task_tag     <= w.tag;
        req_ch.priority_req <= w.prio;
        words_issued++;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // Result side back-pressure
  always @(negedge clk) begin
    if (!rst_n) begin
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= steady || ($urandom_range(99) >= 35);
    end
  end

  // Monitor: check results first, then predict for the word taken this edge
  always @(posedge clk) begin
    outcome_t want;
    if (!rst_n) begin
      req_taken <= 1'b0;
    end else begin
      req_taken <= req_ch.valid && req_ch.ready;
      if (res_ch.valid && res_ch.ready) begin
        if (awaited_results.size() == 0) begin
          $error("result word with none expected (status %0d)", res_ch.status);
          mismatches++;
        end else begin
          want = awaited_results.pop_front();
          check_field("status", want.status, res_ch.status);
          check_field("out_tag", want.tag, res_ch.out_tag);
          check_field("out_priority", want.prio, res_ch.out_priority);
          check_field("running_level", want.level, res_ch.running_level);
          check_field("queued_count", want.count, res_ch.queued_count);
          results_checked++;
        end
      end
      if (req_ch.valid && req_ch.ready)
        advance_task_queue('{op_t'(req_ch.op), req_ch.task_tag, req_ch.priority_req});
    end
  end

  // Watchdog on cycles where no word moves on either channel
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Timeout: no word moved for %0d cycles", STALL_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    int unsigned pick;
    int unsigned depth;
    int unsigned n;
    int unsigned step;
    int          lvl;

    clk                 = 1'b0;
    rst_n               = 1'b0;
    req_ch.valid        = 1'b0;
    req_ch.op           = OP_ADD;
    req_ch.task_tag     = '0;
    req_ch.priority_req = '0;
    res_ch.ready        = 1'b0;
    req_taken           = 1'b0;
    items_queued        = 0;
    words_issued        = 0;
    results_checked     = 0;
    mismatches          = 0;
    quiet_cycles        = 0;
    deepest_nest        = 0;
    foreach (status_hits[i]) status_hits[i] = 0;
    task_count = 0;
    run_level  = IDLE_LEVEL;
    nest_count = 0;

    // Directed: finish while idle, dispatch on empty, unused opcode
    queue_word(OP_FINISH, 16'h0000, 8'h00);
    queue_word(OP_DISPATCH, 16'hFFFF, 8'hFF);
    queue_word(OP_NONE, 16'hFFFF, 8'hFF);
    // fill to the brim: extremes, equal levels keep arrival order
    queue_word(OP_ADD, 16'h0000, 8'h00);
    queue_word(OP_ADD, 16'hFFFF, 8'hFF);
    queue_word(OP_ADD, 16'hA5A5, 8'h00);
    for (int k = 3; k < QUEUE_DEPTH; k++)
      queue_word(OP_ADD, TAG_W'(k * 'h0F0F), LVL_W'(k * 17));
    queue_word(OP_ADD, 16'h5A5A, 8'h80);   // dropped, queue full
    queue_word(OP_DISPATCH, 16'h0000, 8'h00);
    queue_word(OP_DISPATCH, 16'h0000, 8'h00);   // head not more urgent
    queue_word(OP_FINISH, 16'h0000, 8'h00);
    queue_word(OP_FINISH, 16'h0000, 8'h00);     // nothing running

    // Random: nesting chains, fill/drain bursts and loose noise
    while (items_queued < RANDOM_ITEMS) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        // ever more urgent tasks preempt each other, past the stack limit at times
        depth = ($urandom_range(2) == 0) ? NEST_LIMIT + 1 : $urandom_range(1, NEST_LIMIT);
        lvl = $urandom_range(180, 254);
        repeat (depth) begin
          queue_word(OP_ADD, TAG_W'($urandom), LVL_W'(lvl));
          queue_word(OP_DISPATCH, TAG_W'($urandom), LVL_W'($urandom));
          step = $urandom_range(1, 20);
          lvl = (lvl > step) ? lvl - step : 0;
        end
        repeat (depth + $urandom_range(1)) queue_word(OP_FINISH, TAG_W'($urandom), pick_level());
      end else if (pick < 75) begin
        n = $urandom_range(6, QUEUE_DEPTH + 4);
        repeat (n) queue_word(OP_ADD, TAG_W'($urandom), pick_level());
        repeat (n + 1) begin
          queue_word(OP_DISPATCH, TAG_W'($urandom), pick_level());
          if ($urandom_range(9) < 8) queue_word(OP_FINISH, TAG_W'($urandom), pick_level());
        end
      end else begin
        repeat ($urandom_range(1, 6))
          queue_word(op_t'($urandom_range(3)), TAG_W'($urandom), pick_level());
      end
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (stim_words.size() != 0 || req_ch.valid) @(posedge clk);
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d requests, %0d results checked; queued %0d, dropped %0d,",
             words_issued, results_checked, status_hits[ST_QUEUED], status_hits[ST_FULL]);
    $display("  dispatched %0d, not eligible %0d, restored %0d, idle finish %0d, deepest nest %0d",
             status_hits[ST_DISPATCHED], status_hits[ST_NONE_ELIG], status_hits[ST_RESTORED],
             status_hits[ST_NOT_RUN], deepest_nest);
    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
